FILE: rtl/nearest_waypoint_tracker_macros.svh
// ----------------------------------------------------------------------------
// nearest_waypoint_tracker_macros
// Assertion macros used by the checker file of the tracker.
// ----------------------------------------------------------------------------
`ifndef NEAREST_WAYPOINT_TRACKER_MACROS_SVH
`define NEAREST_WAYPOINT_TRACKER_MACROS_SVH

// same-cycle implication
`define NWT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nearest_waypoint_tracker: check failed");

// next-cycle implication
`define NWT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nearest_waypoint_tracker: check failed");

`endif

FILE: rtl/nwt_pkg.sv
// ----------------------------------------------------------------------------
// nwt_pkg
// Field widths, reset values and codes of the nearest waypoint tracker.
// ----------------------------------------------------------------------------
package nwt_pkg;

  localparam int unsigned COORD_W    = 24;
  localparam int unsigned MAG_W      = 24;
  localparam int unsigned SQ_W       = 48;
  localparam int unsigned DIST_W     = 49;
  localparam int unsigned RATE_W     = 8;
  localparam int unsigned WINDOW_W   = 13;
  localparam int unsigned HEAD_W     = 12;
  localparam int unsigned LEFT_W     = 13;
  localparam int unsigned ADV_W      = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [RATE_W-1:0]   RATE_RESET   = 8'd1;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 13'd10;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

endpackage

FILE: rtl/nwt_store.sv
// ----------------------------------------------------------------------------
// nwt_store
// Path point memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nwt_store import nwt_pkg::*; #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned IDX_W = 12
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [IDX_W-1:0]          waddr_i,
  input  logic signed [COORD_W-1:0] wx_i,
  input  logic signed [COORD_W-1:0] wy_i,
  input  logic [IDX_W-1:0]          raddr_i,
  output logic signed [COORD_W-1:0] rx_o,
  output logic signed [COORD_W-1:0] ry_o
);

  logic signed [COORD_W-1:0] mem_x [DEPTH];
  logic signed [COORD_W-1:0] mem_y [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_x[waddr_i] <= wx_i;
      mem_y[waddr_i] <= wy_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_o <= mem_x[raddr_i];
    ry_o <= mem_y[raddr_i];
  end

endmodule

FILE: rtl/nwt_dist.sv
// ----------------------------------------------------------------------------
// nwt_dist
// Shared squared-distance unit: three stages (abs difference, squares, sum),
// a tag rides along with each word.
// ----------------------------------------------------------------------------
module nwt_dist import nwt_pkg::*; #(
  parameter int unsigned TAG_W = 13
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [TAG_W-1:0]          tag_i,
  input  logic signed [COORD_W-1:0] px_i,
  input  logic signed [COORD_W-1:0] py_i,
  input  logic signed [COORD_W-1:0] qx_i,
  input  logic signed [COORD_W-1:0] qy_i,
  output logic                      valid_o,
  output logic [TAG_W-1:0]          tag_o,
  output logic [DIST_W-1:0]         dist_o
);

  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]        ndx, ndy;
  logic [MAG_W-1:0]        ax_q, ay_q;
  logic [SQ_W-1:0]         sx_q, sy_q;
  logic [DIST_W-1:0]       sum_q;
  logic                    v1_q, v2_q, v3_q;
  logic [TAG_W-1:0]        t1_q, t2_q, t3_q;

  assign dx  = {px_i[COORD_W-1], px_i} - {qx_i[COORD_W-1], qx_i};
  assign dy  = {py_i[COORD_W-1], py_i} - {qy_i[COORD_W-1], qy_i};
  assign ndx = -dx;
  assign ndy = -dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= dx[COORD_W] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
    ay_q  <= dy[COORD_W] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];
    t1_q  <= tag_i;
    sx_q  <= ax_q * ax_q;
    sy_q  <= ay_q * ay_q;
    t2_q  <= t1_q;
    sum_q <= DIST_W'(sx_q) + DIST_W'(sy_q);
    t3_q  <= t2_q;
  end

  assign valid_o = v3_q;
  assign tag_o   = t3_q;
  assign dist_o  = sum_q;

endmodule

FILE: rtl/nearest_waypoint_tracker.sv
// ----------------------------------------------------------------------------
// nearest_waypoint_tracker
// Windowed nearest path point search over a stored, downsampled path.
// ----------------------------------------------------------------------------
// Input words carry an opcode and a position. A load word (opcode 0) gives no
// result; one load in every n, n from the rate register, is stored until the
// store is full or the first update has been seen. An update word (opcode 1)
// walks the stored points through one squared-distance unit, one point per
// cycle, and gives one result word: head index, points left, advance, squared
// distance and status. The first update walks all loaded points; later ones
// walk min(search_window, points left), a window of 0 counting as 1. The last
// point read passes the three distance stages, the drain step and the result
// register; the sequencer returns to idle at the edge that writes that
// register, so the next word can be taken while the result is shown. An
// update on an empty path goes straight to the finish step. in_ready_o is
// high only while the sequencer is idle. The result sits in an output
// register; if the receiver stalls, the next load words are still taken, and
// a finished update waits until that register is free. Reset clears the
// counters, head and flags and returns both config registers to their
// defaults; point memory is not cleared, as only loaded entries are ever read.
// ----------------------------------------------------------------------------
module nearest_waypoint_tracker import nwt_pkg::*; #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [HEAD_W-1:0]         head_index_o,
  output logic [LEFT_W-1:0]         points_left_o,
  output logic [ADV_W-1:0]          advance_o,
  output logic [DIST_W-1:0]         distance_sq_o,
  output logic                      status_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned HW = CW + 1;
  localparam int unsigned SW = (CW > WINDOW_W) ? CW : WINDOW_W;
  localparam int unsigned TW = IW + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [RATE_W-1:0]   rate_q;
  logic [WINDOW_W-1:0] window_q;
  logic [CW-1:0]       loaded_q, loaded_d;
  logic [RATE_W-1:0]   phase_q, phase_d;
  logic [IW-1:0]       head_q, head_d;
  logic [CW-1:0]       remaining_q, remaining_d;
  logic                located_q, located_d;
  logic                first_q, first_d;
  logic                empty_q, empty_d;
  logic [IW-1:0]       addr_q, addr_d;
  logic [IW-1:0]       cnt_q, cnt_d;
  logic [IW-1:0]       last_q, last_d;
  logic [IW-1:0]       best_ofs_q, best_ofs_d;
  logic                out_valid_q, out_valid_d;
  logic                iss_valid_q;
  logic [TW-1:0]       iss_tag_q;

  logic signed [COORD_W-1:0] qx_q, qy_q;
  logic signed [COORD_W-1:0] rx, ry;
  logic [DIST_W-1:0]         best_d_q;
  logic [HEAD_W-1:0]         out_head_q;
  logic [LEFT_W-1:0]         out_left_q;
  logic [ADV_W-1:0]          out_adv_q;
  logic [DIST_W-1:0]         out_dist_q;
  logic                      out_status_q;

  logic                in_fire, fin_fire, load_we, keep, store_full, take;
  logic [RATE_W-1:0]   eff_rate;
  logic [RATE_W:0]     phase_inc;
  logic [WINDOW_W-1:0] eff_win;
  logic [SW-1:0]       span;
  logic [IW-1:0]       last_win, last_all, addr_nxt;
  logic [CW-1:0]       addr_inc;
  logic [HW-1:0]       hsum;
  logic [IW-1:0]       new_head;
  logic [CW-1:0]       new_rem;
  logic                dv;
  logic [TW-1:0]       dtag;
  logic [DIST_W-1:0]   dd;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign fin_fire   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  assign eff_rate   = (rate_q == '0) ? RATE_W'(1) : rate_q;
  assign phase_inc  = {1'b0, phase_q} + (RATE_W + 1)'(1);
  assign keep       = phase_inc >= {1'b0, eff_rate};
  assign store_full = loaded_q >= CW'(MAX_POINTS);
  assign load_we    = in_fire && (opcode_i == OP_LOAD) && !located_q && !store_full && keep;

  assign eff_win  = (window_q == '0) ? WINDOW_W'(1) : window_q;
  assign span     = (SW'(eff_win) > SW'(remaining_q)) ? SW'(remaining_q) : SW'(eff_win);
  assign last_win = IW'(span - SW'(1));
  assign last_all = IW'(loaded_q - CW'(1));
  assign addr_inc = CW'(addr_q) + CW'(1);
  assign addr_nxt = (addr_inc == loaded_q) ? '0 : IW'(addr_inc);

  assign hsum     = HW'(head_q) + HW'(best_ofs_q);
  assign new_head = (hsum >= HW'(loaded_q)) ? IW'(hsum - HW'(loaded_q)) : IW'(hsum);
  assign new_rem  = first_q ? loaded_q : (remaining_q - CW'(best_ofs_q));

  assign take = dv && ((dtag[IW-1:0] == '0) || (dd < best_d_q));

  nwt_store #(
    .DEPTH (MAX_POINTS),
    .IDX_W (IW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (IW'(loaded_q)),
    .wx_i    (pos_x_i),
    .wy_i    (pos_y_i),
    .raddr_i (addr_q),
    .rx_o    (rx),
    .ry_o    (ry)
  );

  nwt_dist #(
    .TAG_W (TW)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (iss_valid_q),
    .tag_i   (iss_tag_q),
    .px_i    (rx),
    .py_i    (ry),
    .qx_i    (qx_q),
    .qy_i    (qy_q),
    .valid_o (dv),
    .tag_o   (dtag),
    .dist_o  (dd)
  );

  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q;
    phase_d     = phase_q;
    head_d      = head_q;
    remaining_d = remaining_q;
    located_d   = located_q;
    first_d     = first_q;
    empty_d     = empty_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    best_ofs_d  = take ? dtag[IW-1:0] : best_ofs_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (opcode_i == OP_LOAD) begin
            if (!located_q && !store_full) begin
              if (keep) begin
                phase_d  = '0;
                loaded_d = loaded_q + CW'(1);
              end else begin
                phase_d = phase_inc[RATE_W-1:0];
              end
            end
          end else if (!located_q) begin
            located_d = 1'b1;
            if (loaded_q == '0) begin
              empty_d = 1'b1;
              state_d = ST_FIN;
            end else begin
              empty_d = 1'b0;
              first_d = 1'b1;
              addr_d  = '0;
              cnt_d   = '0;
              last_d  = last_all;
              state_d = ST_SCAN;
            end
          end else if (remaining_q == '0) begin
            empty_d = 1'b1;
            state_d = ST_FIN;
          end else begin
            empty_d = 1'b0;
            first_d = 1'b0;
            addr_d  = head_q;
            cnt_d   = '0;
            last_d  = last_win;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cnt_d  = cnt_q + IW'(1);
        addr_d = addr_nxt;
        if (cnt_q == last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dv && dtag[IW]) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_fire) begin
          out_valid_d = 1'b1;
          if (!empty_q) begin
            head_d      = new_head;
            remaining_d = new_rem;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_q      <= RATE_RESET;
      window_q    <= WINDOW_RESET;
      loaded_q    <= '0;
      phase_q     <= '0;
      head_q      <= '0;
      remaining_q <= '0;
      located_q   <= 1'b0;
      first_q     <= 1'b0;
      empty_q     <= 1'b0;
      addr_q      <= '0;
      cnt_q       <= '0;
      last_q      <= '0;
      best_ofs_q  <= '0;
      out_valid_q <= 1'b0;
      iss_valid_q <= 1'b0;
      iss_tag_q   <= '0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      phase_q     <= phase_d;
      head_q      <= head_d;
      remaining_q <= remaining_d;
      located_q   <= located_d;
      first_q     <= first_d;
      empty_q     <= empty_d;
      addr_q      <= addr_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      best_ofs_q  <= best_ofs_d;
      out_valid_q <= out_valid_d;
      iss_valid_q <= (state_q == ST_SCAN);
      iss_tag_q   <= {cnt_q == last_q, cnt_q};
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_RATE:   rate_q   <= cfg_data_i[RATE_W-1:0];
          CFG_WINDOW: window_q <= cfg_data_i[WINDOW_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  // query position, running minimum and result word
  always_ff @(posedge clk_i) begin
    if (in_fire && (opcode_i == OP_UPDATE)) begin
      qx_q <= pos_x_i;
      qy_q <= pos_y_i;
    end
    if (take) begin
      best_d_q <= dd;
    end
    if (fin_fire) begin
      if (empty_q) begin
        out_head_q   <= '0;
        out_left_q   <= '0;
        out_adv_q    <= '0;
        out_dist_q   <= '0;
        out_status_q <= ST_EMPTY;
      end else begin
        out_head_q   <= HEAD_W'(new_head);
        out_left_q   <= LEFT_W'(new_rem);
        out_adv_q    <= ADV_W'(best_ofs_q);
        out_dist_q   <= best_d_q;
        out_status_q <= ST_OK;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign head_index_o  = out_head_q;
  assign points_left_o = out_left_q;
  assign advance_o     = out_adv_q;
  assign distance_sq_o = out_dist_q;
  assign status_o      = out_status_q;

endmodule

FILE: rtl/nwt_checker.sv
// ----------------------------------------------------------------------------
// nwt_checker
// Port-level checks of the nearest waypoint tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "nearest_waypoint_tracker_macros.svh"

module nwt_checker import nwt_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      opcode_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [HEAD_W-1:0]         head_index_o,
  input logic [LEFT_W-1:0]         points_left_o,
  input logic [ADV_W-1:0]          advance_o,
  input logic [DIST_W-1:0]         distance_sq_o,
  input logic                      status_o
);

  `NWT_ASSERT_NEXT(a_update_busy, in_valid_i && in_ready_o && opcode_i == OP_UPDATE, !in_ready_o)
  `NWT_ASSERT_NEXT(a_load_silent, in_valid_i && in_ready_o && opcode_i == OP_LOAD && !out_valid_o, !out_valid_o)
  `NWT_ASSERT_NOW(a_empty_zero, out_valid_o && status_o == ST_EMPTY, head_index_o == '0 && points_left_o == '0 && advance_o == '0 && distance_sq_o == '0)
  `NWT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(distance_sq_o) && $stable(head_index_o))

endmodule

bind nearest_waypoint_tracker nwt_checker u_checker (.*);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest waypoint tracker. A queue-fed driver
// offers load and update words with random gaps, while a monitor stalls the
// result side at random and checks every result word against a shadow
// tracker that follows the stored path, the head and the points left. The run
// loads a path, then steers a vehicle along it under changing search windows.
// ----------------------------------------------------------------------------
module testbench;
  import nwt_pkg::*;

  localparam int unsigned MAX_WP   = 4096;
  localparam int unsigned PATH_LEN = 640;
  localparam int unsigned WIN_TOP  = 8191;
  localparam int unsigned LATE_CYC = 12;
  localparam int unsigned HOLD_AT  = 150;
  localparam int unsigned HOLD_CYC = 800;
  localparam int unsigned N_UPD    = 580;

  typedef struct {
    logic                      op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    int unsigned               gap;
  } word_t;

  typedef struct {
    logic [HEAD_W-1:0] head;
    logic [LEFT_W-1:0] left;
    logic [ADV_W-1:0]  adv;
    logic [DIST_W-1:0] dsq;
    logic              status;
  } fix_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic                      opcode_i    = OP_LOAD;
  logic signed [COORD_W-1:0] pos_x_i     = '0;
  logic signed [COORD_W-1:0] pos_y_i     = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [HEAD_W-1:0]         head_index_o;
  logic [LEFT_W-1:0]         points_left_o;
  logic [ADV_W-1:0]          advance_o;
  logic [DIST_W-1:0]         distance_sq_o;
  logic                      status_o;
  logic                      cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i = CFG_RATE;
  logic [CFG_DATA_W-1:0]     cfg_data_i  = '0;

  word_t       word_q[$];
  fix_t        fix_q[$];
  word_t       nxt;
  fix_t        want;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned fixes_seen = 0;
  bit          held       = 1'b0;
  bit          no_idle    = 1'b0;
  int unsigned errors     = 0;

  // shadow tracker
  logic signed [COORD_W-1:0] wp_x [MAX_WP];
  logic signed [COORD_W-1:0] wp_y [MAX_WP];
  int unsigned         wp_count   = 0;
  int unsigned         skip_phase = 0;
  int unsigned         trk_head   = 0;
  int unsigned         trk_left   = 0;
  bit                  is_located = 1'b0;
  logic [RATE_W-1:0]   cfg_rate   = RATE_RESET;
  logic [WINDOW_W-1:0] cfg_window = WINDOW_RESET;

  nearest_waypoint_tracker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .head_index_o (head_index_o),
    .points_left_o(points_left_o),
    .advance_o    (advance_o),
    .distance_sq_o(distance_sq_o),
    .status_o     (status_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial forever #6 clk_i = ~clk_i;

  function automatic longint unsigned sq_dist(int unsigned idx,
                                              logic signed [COORD_W-1:0] x,
                                              logic signed [COORD_W-1:0] y);
    longint dx, dy;
    dx = longint'(wp_x[idx]) - longint'(x);
    dy = longint'(wp_y[idx]) - longint'(y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return longint'(dx * dx + dy * dy);
  endfunction

  task automatic follow_path(logic op, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y);
    int unsigned     rate, win, best, step, idx, i;
    longint unsigned best_d, d;
    fix_t            fx;
    best   = 0;
    step   = 0;
    best_d = 0;
    if (op == OP_LOAD) begin
      rate = (cfg_rate == 0) ? 1 : cfg_rate;
      if (!is_located && wp_count < MAX_WP) begin
        if (skip_phase + 1 >= rate) begin
          skip_phase     = 0;
          wp_x[wp_count] = x;
          wp_y[wp_count] = y;
          wp_count++;
        end else begin
          skip_phase = (skip_phase + 1) & 8'hFF;
        end
      end
    end else begin
      if (!is_located) begin
        is_located = 1'b1;
        if (wp_count != 0) begin
          best_d = sq_dist(0, x, y);
          for (i = 1; i < wp_count; i++) begin
            d = sq_dist(i, x, y);
            if (d < best_d) begin
              best_d = d;
              best   = i;
            end
          end
          trk_head = best;
          step     = best;
          trk_left = wp_count;
        end
      end else if (trk_left != 0 && wp_count != 0) begin
        win = (cfg_window == 0) ? 1 : cfg_window;
        if (win > trk_left) win = trk_left;
        for (i = 0; i < win; i++) begin
          idx = trk_head + i;
          if (idx >= wp_count) idx -= wp_count;
          d = sq_dist(idx, x, y);
          if (i == 0 || d < best_d) begin
            best_d = d;
            best   = i;
          end
        end
        step     = best;
        trk_head = trk_head + best;
        if (trk_head >= wp_count) trk_head -= wp_count;
        trk_left = trk_left - best;
      end
      if (trk_left == 0) begin
        fx.head   = '0;
        fx.left   = '0;
        fx.adv    = '0;
        fx.dsq    = '0;
        fx.status = ST_EMPTY;
      end else begin
        fx.head   = trk_head[HEAD_W-1:0];
        fx.left   = trk_left[LEFT_W-1:0];
        fx.adv    = step[ADV_W-1:0];
        fx.dsq    = best_d[DIST_W-1:0];
        fx.status = ST_OK;
      end
      fix_q.insert(fix_q.size(), fx);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 99) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic push_word(logic op, int x, int y);
    word_t w;
    w.op  = op;
    w.x   = x[COORD_W-1:0];
    w.y   = y[COORD_W-1:0];
    w.gap = no_idle ? 0 : pick_gap();
    word_q.insert(word_q.size(), w);
  endtask

  task automatic push_near(int unsigned idx);
    int unsigned i;
    i = idx % wp_count;
    push_word(OP_UPDATE, int'(wp_x[i]) + int'($urandom_range(0, 600)) - 300,
              int'(wp_y[i]) + int'($urandom_range(0, 600)) - 300);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (word_q.size() != 0 || in_valid_i || fix_q.size() != 0) @(negedge clk_i);
    repeat (LATE_CYC) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_RATE) cfg_rate = val[RATE_W-1:0];
    else cfg_window = val[WINDOW_W-1:0];
    @(negedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) follow_path(opcode_i, pos_x_i, pos_y_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (word_q.size() != 0) begin
          nxt = word_q.pop_front();
          in_valid_i <= 1'b1;
          opcode_i   <= nxt.op;
          pos_x_i    <= nxt.x;
          pos_y_i    <= nxt.y;
          gap_left   <= nxt.gap;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        fixes_seen++;
        if (fix_q.size() == 0) begin
          errors++;
          $display("%0t result word with nothing expected", $time);
        end else begin
          want = fix_q.pop_front();
          check_field("head_index", want.head, head_index_o);
          check_field("points_left", want.left, points_left_o);
          check_field("advance", want.adv, advance_o);
          check_field("distance_sq", want.dsq, distance_sq_o);
          check_field("status", want.status, status_o);
        end
      end
      // one long hold-off so the block backs up into its input
      if (fixes_seen >= HOLD_AT && !held && word_q.size() != 0) begin
        held       = 1'b1;
        stall_left = HOLD_CYC;
      end
      if (stall_left == 0 && !no_idle && $urandom_range(0, 3) == 0)
        stall_left = 1 + pick_gap();
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned v, left, w, weff, cap, step, n, r, updates;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corners, then a duplicate point for a tie
    push_word(OP_LOAD, 8388607, 8388607);
    push_word(OP_LOAD, -8388608, -8388608);
    push_word(OP_LOAD, 8388607, -8388608);
    push_word(OP_LOAD, -8388608, 8388607);
    push_word(OP_LOAD, 0, 0);
    push_word(OP_LOAD, -1, 1);
    push_word(OP_LOAD, 0, 0);
    wait_idle();
    write_cfg(CFG_RATE, 0);
    repeat (3) push_word(OP_LOAD, rand_coord(), rand_coord());
    wait_idle();
    write_cfg(CFG_RATE, 5);
    repeat (3) push_word(OP_LOAD, rand_coord(), rand_coord());
    wait_idle();
    // rate lowered mid-count
    write_cfg(CFG_RATE, 2);
    repeat (3) push_word(OP_LOAD, rand_coord(), rand_coord());
    wait_idle();
    write_cfg(CFG_RATE, 255);
    repeat (256) push_word(OP_LOAD, rand_coord(), rand_coord());
    wait_idle();
    write_cfg(CFG_RATE, 1);

    // path along x with a zigzag in y
    for (int k = wp_count; k < PATH_LEN; k++)
      push_word(OP_LOAD, -6000000 + k * 2500 + int'($urandom_range(0, 800)) - 400,
                1000000 + ((k % 64) - 32) * 300 + int'($urandom_range(0, 800)) - 400);
    repeat (4) push_word(OP_LOAD, rand_coord(), rand_coord());

    wait_idle();
    write_cfg(CFG_WINDOW, 0);
    push_near(PATH_LEN - 196);
    push_near(PATH_LEN - 193);
    push_word(OP_LOAD, 0, 0);
    wait_idle();
    write_cfg(CFG_WINDOW, WIN_TOP);
    push_word(OP_UPDATE, 8388607, 8388607);
    wait_idle();
    write_cfg(CFG_WINDOW, 1);
    push_word(OP_UPDATE, -8388608, -8388608);
    wait_idle();
    write_cfg(CFG_WINDOW, 10);
    push_word(OP_UPDATE, 0, 0);

    updates = 0;
    while (updates < N_UPD) begin
      wait_idle();
      r = $urandom_range(0, 99);
      if (r < 4) w = 0;
      else if (r < 8) w = 1;
      else if (r < 10) w = MAX_WP;
      else if (r < 11) w = WIN_TOP;
      else w = $urandom_range(2, 48);
      write_cfg(CFG_WINDOW, w);
      no_idle = ($urandom_range(0, 7) == 0);
      v    = trk_head;
      left = trk_left;
      n    = (w > 64) ? $urandom_range(2, 5) : $urandom_range(20, 60);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          push_word(OP_LOAD, rand_coord(), rand_coord());
        end else begin
          if (r < 8 && w <= 64) begin
            push_word(OP_UPDATE, rand_coord(), rand_coord());
          end else begin
            weff = (w == 0) ? 1 : w;
            if (weff > left) weff = left;
            cap = (left > 500) ? 5 : 1;
            if (weff == 0) cap = 0;
            else if (cap > weff - 1) cap = weff - 1;
            step = $urandom_range(0, cap);
            v    = (v + step) % wp_count;
            left = left - step;
            push_near(v);
          end
          updates++;
        end
      end
    end
    no_idle = 1'b0;

    // run to the last point, then windows clamped to what is left
    wait_idle();
    write_cfg(CFG_WINDOW, MAX_WP);
    if (trk_left > 1) push_near(trk_head + trk_left - 1);
    wait_idle();
    write_cfg(CFG_WINDOW, WIN_TOP);
    repeat (5) push_near(trk_head + $urandom_range(0, 3));
    wait_idle();

    if (errors == 0 && fix_q.size() == 0) begin
      $display("nearest_waypoint_tracker verification clean");
    end else begin
      $display("nearest_waypoint_tracker verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("nearest_waypoint_tracker verification failed");
    $finish;
  end

endmodule
